>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define QRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// assertion on a result transaction shown at the output
`define QRS_ASSERT_ON_OUT(label, pre, post, msg) \
    `QRS_ASSERT(label, i_out_valid && (pre) |-> (post), msg)

`endif

>>> hw/rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared types and constants of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_TWO  = 2'd2,
        KIND_INF  = 2'd3
    } t_root_kind;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

endpackage

>>> hw/rtl/qrs_coef_if.sv
// ----------------------------------------------------------------------------
// qrs_coef_if
// coefficient channel: valid, ready and the three coefficients
// ----------------------------------------------------------------------------
interface qrs_coef_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] coef_a;
    logic signed [W-1:0] coef_b;
    logic signed [W-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

>>> hw/rtl/qrs_root_if.sv
// ----------------------------------------------------------------------------
// qrs_root_if
// result channel: valid, ready, root kind, the two roots and overflow
// ----------------------------------------------------------------------------
interface qrs_root_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic [1:0]          root_kind;
    logic signed [W-1:0] root_first;
    logic signed [W-1:0] root_second;
    logic                overflow;

    modport source (output valid, output root_kind, output root_first, output root_second,
                    output overflow, input ready);
    modport sink   (input valid, input root_kind, input root_first, input root_second,
                    input overflow, output ready);
endinterface

>>> hw/rtl/quadratic_root_solver_top.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// real roots of a*x^2 + b*x + c = 0 in signed fixed point
// ----------------------------------------------------------------------------
// i_coef carries one coefficient set per transaction (coef_a, coef_b, coef_c,
// signed Q(COEF_WIDTH-FRAC_BITS).FRAC_BITS); o_root returns exactly one
// result per set, in order: root_kind, root_first, root_second, overflow.
// both channels complete a transaction when valid and ready are high.
// throughput is one set per cycle while the receiver takes results. the path
// runs through one input stage, the job queue, COEF_WIDTH+1 square-root
// stages, COEF_WIDTH+2+FRAC_BITS divider stages and the output register.
// the divider's one-quotient-bit-per-stage pipeline sets the depth.
// a stalled receiver freezes the back pipeline; the front keeps accepting
// until the four-entry queue and its input stage are full, then drops ready.
// synchronous active-low reset empties all stages and the queue; no result
// is shown until a new set is accepted.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qrs_coef_if.sink    i_coef,
    qrs_root_if.source  o_root
);

    localparam int W  = COEF_WIDTH;
    localparam int DW = 2*W + 2;
    localparam int RW = W + 1;
    localparam int NW = W + 3;
    localparam int SW = 2 + 2*(W+1);
    localparam int EW = SW + DW;

    qrs_pkg::t_root_kind w_f_kind;
    logic [DW-1:0]       w_f_disc;
    logic signed [W:0]   w_f_nb;
    logic signed [W:0]   w_f_den;
    logic                w_push;

    qrs_pkg::t_fifo_stat w_q_stat;
    logic [EW-1:0]       w_q_data;
    logic                w_pop;
    logic                w_en;

    logic                w_s_valid;
    logic [RW-1:0]       w_s_root;
    logic [SW-1:0]       w_s_side;
    qrs_pkg::t_root_kind w_s_kind;
    logic signed [W:0]   w_s_nb;
    logic signed [W:0]   w_s_den;
    logic signed [NW-1:0] w_nbx;
    logic signed [NW-1:0] w_sx;
    logic signed [NW-1:0] w_num1;
    logic signed [NW-1:0] w_num2;

    logic                w_d_valid;
    qrs_pkg::t_root_kind w_d_kind;
    logic signed [W-1:0] w_d_first;
    logic signed [W-1:0] w_d_second;
    logic                w_d_ovf;

    logic                r_out_valid;
    qrs_pkg::t_root_kind r_kind;
    logic signed [W-1:0] r_first;
    logic signed [W-1:0] r_second;
    logic                r_ovf;

    qrs_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_coef.valid),
        .o_ready (i_coef.ready),
        .i_a     (i_coef.coef_a),
        .i_b     (i_coef.coef_b),
        .i_c     (i_coef.coef_c),
        .i_full  (w_q_stat.full),
        .o_push  (w_push),
        .o_kind  (w_f_kind),
        .o_disc  (w_f_disc),
        .o_nb    (w_f_nb),
        .o_den   (w_f_den)
    );

    qrs_fifo #(.WIDTH(EW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_kind, w_f_disc, w_f_nb, w_f_den}),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_data  (w_q_data)
    );

    assign w_en  = !r_out_valid || o_root.ready;
    assign w_pop = w_en && !w_q_stat.empty;

    qrs_sqrt #(.RW(RW), .SW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_pop),
        .i_d     (w_q_data[EW-3 -: DW]),
        .i_side  ({w_q_data[EW-1 -: 2], w_q_data[SW-3:0]}),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    assign w_s_kind = qrs_pkg::t_root_kind'(w_s_side[SW-1 -: 2]);
    assign w_s_nb   = $signed(w_s_side[2*W+1 -: W+1]);
    assign w_s_den  = $signed(w_s_side[W:0]);
    assign w_nbx    = NW'(w_s_nb);
    assign w_sx     = $signed({2'b00, w_s_root});
    assign w_num1   = w_nbx - w_sx;
    assign w_num2   = (w_s_kind == qrs_pkg::KIND_TWO) ? (w_nbx + w_sx) : '0;

    qrs_div #(.W(W), .F(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_s_valid),
        .i_kind   (w_s_kind),
        .i_num1   (w_num1),
        .i_num2   (w_num2),
        .i_den    (w_s_den),
        .o_valid  (w_d_valid),
        .o_kind   (w_d_kind),
        .o_first  (w_d_first),
        .o_second (w_d_second),
        .o_ovf    (w_d_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind   <= w_d_kind;
            r_first  <= w_d_first;
            r_second <= w_d_second;
            r_ovf    <= w_d_ovf;
        end
    end

    assign o_root.valid       = r_out_valid;
    assign o_root.root_kind   = r_kind;
    assign o_root.root_first  = r_first;
    assign o_root.root_second = r_second;
    assign o_root.overflow    = r_ovf;

endmodule

>>> hw/rtl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// takes coefficients, forms b^2 and |a*c|, classifies and builds the job
// ----------------------------------------------------------------------------
module qrs_front #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    input  logic signed [W-1:0]   i_c,
    input  logic                  i_full,
    output logic                  o_push,
    output qrs_pkg::t_root_kind   o_kind,
    output logic [2*W+1:0]        o_disc,
    output logic signed [W:0]     o_nb,
    output logic signed [W:0]     o_den
);

    logic                r_valid;
    logic signed [W-1:0] r_a;
    logic signed [W-1:0] r_b;
    logic signed [W-1:0] r_c;
    logic [2*W-1:0]      r_bb;
    logic [2*W-1:0]      r_p;

    logic [W-1:0]        w_ma;
    logic [W-1:0]        w_mb;
    logic [W-1:0]        w_mc;
    logic [2*W+1:0]      w_q4;
    logic [2*W+1:0]      w_bb;
    logic                w_opp;
    logic signed [W:0]   w_bx;
    logic signed [W:0]   w_cx;
    logic signed [W:0]   w_a2;

    assign w_ma = i_a[W-1] ? W'(-i_a) : W'(i_a);
    assign w_mb = i_b[W-1] ? W'(-i_b) : W'(i_b);
    assign w_mc = i_c[W-1] ? W'(-i_c) : W'(i_c);

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_c  <= i_c;
            r_bb <= (2*W)'(w_mb) * (2*W)'(w_mb);
            r_p  <= (2*W)'(w_ma) * (2*W)'(w_mc);
        end
    end

    assign w_q4  = {r_p, 2'b00};
    assign w_bb  = {2'b00, r_bb};
    assign w_opp = (r_p != '0) && (r_a[W-1] != r_c[W-1]);
    assign w_bx  = {r_b[W-1], r_b};
    assign w_cx  = {r_c[W-1], r_c};
    assign w_a2  = {r_a, 1'b0};

    always_comb begin
        o_kind = qrs_pkg::KIND_NONE;
        o_disc = '0;
        o_nb   = '0;
        o_den  = (W+1)'(1);
        priority if (r_a == '0) begin
            if (r_b == '0) begin
                o_kind = (r_c == '0) ? qrs_pkg::KIND_INF : qrs_pkg::KIND_NONE;
            end else begin
                o_kind = qrs_pkg::KIND_ONE;
                o_nb   = -w_cx;
                o_den  = w_bx;
            end
        end else if (w_opp) begin
            o_kind = qrs_pkg::KIND_TWO;
            o_disc = w_bb + w_q4;
            o_nb   = -w_bx;
            o_den  = w_a2;
        end else if (w_q4 > w_bb) begin
            o_kind = qrs_pkg::KIND_NONE;
        end else if (w_q4 == w_bb) begin
            o_kind = qrs_pkg::KIND_ONE;
            o_nb   = -w_bx;
            o_den  = w_a2;
        end else begin
            o_kind = qrs_pkg::KIND_TWO;
            o_disc = w_bb - w_q4;
            o_nb   = -w_bx;
            o_den  = w_a2;
        end
    end

endmodule

>>> hw/rtl/qrs_fifo.sv
// ----------------------------------------------------------------------------
// qrs_fifo
// short job queue between the front and the back pipeline
// ----------------------------------------------------------------------------
module qrs_fifo #(
    parameter int WIDTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_data,
    input  logic                i_pop,
    output qrs_pkg::t_fifo_stat o_stat,
    output logic [WIDTH-1:0]    o_data
);

    localparam int AW = qrs_pkg::FIFO_AW;

    logic [WIDTH-1:0] r_mem [qrs_pkg::FIFO_DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;

    assign o_stat.full  = (r_cnt == (AW+1)'(qrs_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int RW = 33,
    parameter int SW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_d,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    logic            r_v    [RW];
    logic [SW-1:0]   r_side [RW];
    logic [2*RW-1:0] r_d    [RW];
    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            w_v_in;
        logic [SW-1:0]   w_side_in;
        logic [2*RW-1:0] w_d_in;
        logic [RW+1:0]   w_rem_in;
        logic [RW-1:0]   w_root_in;
        logic [RW+1:0]   w_rem_sh;
        logic [RW+1:0]   w_trial;
        logic            w_ge;

        if (k == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_side_in = i_side;
            assign w_d_in    = i_d;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_side_in = r_side[k-1];
            assign w_d_in    = r_d[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
        end

        assign w_rem_sh = {w_rem_in[RW-1:0], w_d_in[2*RW-1 -: 2]};
        assign w_trial  = {w_root_in, 2'b01};
        assign w_ge     = (w_rem_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side_in;
                r_d[k]    <= w_d_in << 2;
                r_rem[k]  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root[k] <= {w_root_in[RW-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

>>> hw/rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// two-lane pipelined fixed-point divider with saturation, one bit per stage
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  qrs_pkg::t_root_kind i_kind,
    input  logic signed [W+2:0] i_num1,
    input  logic signed [W+2:0] i_num2,
    input  logic signed [W:0]   i_den,
    output logic                o_valid,
    output qrs_pkg::t_root_kind o_kind,
    output logic signed [W-1:0] o_first,
    output logic signed [W-1:0] o_second,
    output logic                o_ovf
);

    localparam int NW = W + 3;
    localparam int GW = W + 2;
    localparam int MW = W + 2 + F;

    logic                r_v    [MW];
    qrs_pkg::t_root_kind r_kind [MW];
    logic [W:0]          r_dm   [MW];
    logic [MW-1:0]       r_n    [2][MW];
    logic [W:0]          r_rem  [2][MW];
    logic [MW-1:0]       r_q    [2][MW];
    logic                r_neg  [2][MW];

    logic [W:0]          w_dm;
    logic signed [NW-1:0] w_num [2];
    logic [MW-1:0]       w_n0   [2];
    logic                w_neg0 [2];
    logic signed [W-1:0] w_res  [2];
    logic                w_sat  [2];

    assign w_dm     = i_den[W] ? (W+1)'(-i_den) : (W+1)'(i_den);
    assign w_num[0] = i_num1;
    assign w_num[1] = i_num2;

    for (genvar k = 0; k < MW; k++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_kind[k] <= (k == 0) ? i_kind : r_kind[(k == 0) ? 0 : k-1];
                r_dm[k]   <= (k == 0) ? w_dm   : r_dm[(k == 0) ? 0 : k-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [GW-1:0] w_mag;
        logic [MW-1:0] w_lim;

        assign w_mag     = w_num[l][NW-1] ? GW'(-w_num[l]) : GW'(w_num[l]);
        assign w_n0[l]   = MW'(w_mag) << F;
        assign w_neg0[l] = (w_num[l][NW-1] != i_den[W]);

        for (genvar k = 0; k < MW; k++) begin : g_stage
            logic [MW-1:0] w_n_in;
            logic [W:0]    w_rem_in;
            logic [MW-1:0] w_q_in;
            logic          w_neg_in;
            logic [W:0]    w_dm_in;
            logic [W+1:0]  w_rem_sh;
            logic          w_ge;

            if (k == 0) begin : g_first
                assign w_n_in   = w_n0[l];
                assign w_rem_in = '0;
                assign w_q_in   = '0;
                assign w_neg_in = w_neg0[l];
                assign w_dm_in  = w_dm;
            end else begin : g_next
                assign w_n_in   = r_n[l][k-1];
                assign w_rem_in = r_rem[l][k-1];
                assign w_q_in   = r_q[l][k-1];
                assign w_neg_in = r_neg[l][k-1];
                assign w_dm_in  = r_dm[k-1];
            end

            assign w_rem_sh = {w_rem_in, w_n_in[MW-1]};
            assign w_ge     = (w_rem_sh >= {1'b0, w_dm_in});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[l][k]   <= w_n_in << 1;
                    r_rem[l][k] <= w_ge ? (W+1)'(w_rem_sh - {1'b0, w_dm_in}) : w_rem_sh[W:0];
                    r_q[l][k]   <= {w_q_in[MW-2:0], w_ge};
                    r_neg[l][k] <= w_neg_in;
                end
            end
        end

        // saturate to the signed coefficient range
        always_comb begin
            w_lim = MW'(1) << (W-1);
            if (!r_neg[l][MW-1]) begin
                w_lim = w_lim - MW'(1);
            end
            w_sat[l] = (r_q[l][MW-1] > w_lim);
            w_res[l] = w_sat[l] ? W'(w_lim) : W'(r_q[l][MW-1]);
            if (r_neg[l][MW-1]) begin
                w_res[l] = -w_res[l];
            end
        end
    end

    assign o_valid  = r_v[MW-1];
    assign o_kind   = r_kind[MW-1];
    assign o_first  = w_res[0];
    assign o_second = w_res[1];
    assign o_ovf    = w_sat[0] | w_sat[1];

endmodule

>>> hw/rtl/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qrs_checker #(
    parameter int W = 32
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [1:0]          i_kind,
    input logic signed [W-1:0] i_first,
    input logic signed [W-1:0] i_second,
    input logic                i_ovf
);

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // stalled transaction holds
    `QRS_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_first) && $stable(i_second) && $stable(i_ovf), "stalled result changed")

    `QRS_ASSERT_ON_OUT(a_no_roots_zero, i_kind == qrs_pkg::KIND_NONE || i_kind == qrs_pkg::KIND_INF, i_first == '0 && i_second == '0 && !i_ovf, "unreported roots not zero")

    `QRS_ASSERT_ON_OUT(a_one_root_second_zero, i_kind == qrs_pkg::KIND_ONE, i_second == '0, "second root not zero for one root")

    `QRS_ASSERT_ON_OUT(a_ovf_saturated, i_ovf, i_first == MAXV || i_first == MINV || i_second == MAXV || i_second == MINV, "overflow without saturated root")

endmodule

bind quadratic_root_solver_top qrs_checker #(.W(COEF_WIDTH)) u_qrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_root.valid),
    .i_out_ready (o_root.ready),
    .i_kind      (o_root.root_kind),
    .i_first     (o_root.root_first),
    .i_second    (o_root.root_second),
    .i_ovf       (o_root.overflow)
);
